// ===== rtl/core/structure_factor_accumulator_defines.svh =====
// assertion macros for the structure factor accumulator
`ifndef STRUCTURE_FACTOR_ACCUMULATOR_DEFINES_SVH
`define STRUCTURE_FACTOR_ACCUMULATOR_DEFINES_SVH
// implication checked every cycle outside reset
`define SFA_ASSERT_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) else $error("lbl");
// next-cycle implication
`define SFA_ASSERT_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) else $error("lbl");
`endif

// ===== rtl/core/sfa_pkg.sv =====
// shared types and constants of the structure factor accumulator
package sfa_pkg;
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ACCUM = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam int SumW = 48;
  localparam logic [63:0] CoefA = 64'd1686629713;
  localparam logic [63:0] CoefB = 64'd688904866;
  localparam logic [63:0] CoefC = 64'd76016977;

  typedef struct packed {
    logic [1:0] command;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic signed [15:0] scatter_len;
    logic [7:0] entry_index;
  } sfa_in_t;

  typedef struct packed {
    logic signed [3:0] k_x;
    logic signed [3:0] k_y;
    logic signed [3:0] k_z;
    logic signed [47:0] c_sum;
    logic signed [47:0] s_sum;
    logic entry_valid;
    logic [8:0] entry_count;
  } sfa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SWEEP, ST_DRAIN, ST_OUT
  } sfa_state_t;
endpackage

// ===== rtl/core/structure_factor_accumulator.sv =====
// structure factor accumulator: lattice sweep over ram-held fourier sums
// operation: accumulate and read scan all (2*order+1)^3 lattice points of the effective
//   order, one read-modify-write per cycle, then drain the pipeline; a read result is
//   loaded into the output register after the drain, later while that register is held
// throughput: sequential; the next request is taken once an accumulate has drained, and
//   once a read has also passed its output state. clear and reset (rst, synchronous) run a
//   clearing pass over all (2*MAX_ORDER+1)^3 ram entries with in_ready low
module structure_factor_accumulator #(
  parameter int MAX_ORDER  = 4,
  parameter int PHASE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfa_pkg::sfa_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sfa_pkg::sfa_out_t   out_data
);
  import sfa_pkg::*;

  localparam int Side  = 2 * MAX_ORDER + 1;
  localparam int Slots = Side * Side * Side;
  localparam int AW    = $clog2(Slots);
  localparam int CW    = $clog2(Side);
  localparam int PW    = PHASE_BITS;
  localparam int QW    = PHASE_BITS - 2;

  // configuration
  logic [2:0] kvec_order;
  always_ff @(posedge clk) begin
    if (rst) kvec_order <= 3'd1;
    else if (cfg_we) kvec_order <= cfg_wdata;
  end
  logic [2:0] ord;
  always_comb begin
    if (kvec_order == 3'd0) ord = 3'd1;
    else if (32'(kvec_order) > MAX_ORDER) ord = 3'(MAX_ORDER);
    else ord = kvec_order;
  end

  // request register and control
  sfa_in_t req;
  sfa_state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic signed [CW:0] ci, cj, ck;     // signed lattice counters, from -order to order
  logic [8:0] lidx;                   // entry number of next shell point
  logic [3:0] drain;

  // output register, fed from a staging copy so a held result stays put
  sfa_out_t res;
  sfa_out_t hit;
  sfa_out_t res_next;
  logic res_valid;
  assign out_valid = res_valid;
  assign out_data  = res;

  always_comb begin
    res_next = hit;
    res_next.entry_count = lidx;
  end

  logic sweep_last;
  assign sweep_last = (ci == (CW+1)'(ord)) && (cj == (CW+1)'(ord)) && (ck == (CW+1)'(ord));

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.command == CMD_CLEAR) state_next = ST_CLEAR;
          else if (in_data.command == CMD_NONE) state_next = ST_IDLE;
          else state_next = ST_SWEEP;
        end
      end
      ST_CLEAR: if (clr_addr == AW'(Slots - 1)) state_next = ST_IDLE;
      ST_SWEEP: if (sweep_last) state_next = ST_DRAIN;
      ST_DRAIN: if (drain == 4'd0) state_next =
                  (req.command == CMD_READ) ? ST_OUT : ST_IDLE;
      ST_OUT:   if (!res_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // shell membership of the current scan point
  logic signed [CW:0] cur_i, cur_j, cur_k;
  assign cur_i = ci; assign cur_j = cj; assign cur_k = ck;
  logic [7:0] nrm;
  assign nrm = 8'(cur_i * cur_i) + 8'(cur_j * cur_j) + 8'(cur_k * cur_k);
  logic in_shell;
  assign in_shell = (state == ST_SWEEP) && (nrm != 8'd0) &&
                    (nrm <= 8'(ord * ord)) && (32'(lidx) < Slots);

  // stage 1: phase
  logic        s1_v;
  logic [AW-1:0] s1_a;
  logic [15:0] s1_ph;
  logic signed [3:0] s1_i, s1_j, s1_k;
  // stage pipeline for accumulate: s1 phase, s2 square, s3 poly c, s4 poly a, s5 times t,
  // s6 products (ram data valid) and write
  always_ff @(posedge clk) begin
    s1_v  <= in_shell;
    s1_a  <= AW'(lidx);
    s1_ph <= 16'(32'(cur_i) * 32'(req.pos_x) + 32'(cur_j) * 32'(req.pos_y)
                 + 32'(cur_k) * 32'(req.pos_z));
    s1_i  <= 4'(cur_i); s1_j <= 4'(cur_j); s1_k <= 4'(cur_k);
  end

  // phase conversion and quadrant split for sine and cosine
  logic [PW-1:0] ph_s, ph_c;
  always_comb begin
    if (PW <= 16) ph_s = PW'(s1_ph >> (16 - PW));
    else ph_s = PW'({s1_ph, {((PW > 16) ? PW - 16 : 1){1'b0}}} >> ((PW > 16) ? 0 : 1));
    ph_c = ph_s + (PW'(1) << QW);
  end

  // q30 position within the quadrant, mirrored in odd quadrants
  function automatic logic [31:0] t_of(input logic [PW-1:0] p);
    logic [31:0] t;
    t = 32'(p[QW-1:0]) << (32 - PW);
    if (p[QW]) t = (32'd1 << 30) - t;
    return t;
  endfunction

  logic [31:0] t_s1, t_c1;
  assign t_s1 = t_of(ph_s);
  assign t_c1 = t_of(ph_c);

  // polynomial stages, both channels in parallel; all q30 values fit in 32 bits
  logic [31:0] t_s, t_c, t2_s, t2_c, u_s, u_c, w_s, w_c;
  logic [1:0]  q_s2, q_c2, q_s3, q_c3, q_s4, q_c4, q_s5, q_c5;
  logic        s2_v, s3_v, s4_v;
  logic [AW-1:0] s2_a, s3_a, s4_a;
  logic signed [3:0] s2_i, s2_j, s2_k, s3_i, s3_j, s3_k, s4_i, s4_j, s4_k;
  always_ff @(posedge clk) begin
    s2_v <= s1_v; s2_a <= s1_a;
    s2_i <= s1_i; s2_j <= s1_j; s2_k <= s1_k;
    t_s  <= t_s1; t_c <= t_c1;
    t2_s <= 32'((64'(t_s1) * 64'(t_s1)) >> 30);
    t2_c <= 32'((64'(t_c1) * 64'(t_c1)) >> 30);
    q_s2 <= ph_s[PW-1:PW-2]; q_c2 <= ph_c[PW-1:PW-2];
  end
  logic [31:0] t_s3, t_c3, t2_s3, t2_c3;
  always_ff @(posedge clk) begin
    s3_v <= s2_v; s3_a <= s2_a;
    s3_i <= s2_i; s3_j <= s2_j; s3_k <= s2_k;
    u_s <= 32'(CoefB - ((CoefC * 64'(t2_s)) >> 30));
    u_c <= 32'(CoefB - ((CoefC * 64'(t2_c)) >> 30));
    t_s3 <= t_s; t_c3 <= t_c; t2_s3 <= t2_s; t2_c3 <= t2_c;
    q_s3 <= q_s2; q_c3 <= q_c2;
  end
  logic [31:0] t_s4, t_c4;
  always_ff @(posedge clk) begin
    s4_v <= s3_v; s4_a <= s3_a;
    s4_i <= s3_i; s4_j <= s3_j; s4_k <= s3_k;
    w_s <= 32'(CoefA - ((64'(u_s) * 64'(t2_s3)) >> 30));
    w_c <= 32'(CoefA - ((64'(u_c) * 64'(t2_c3)) >> 30));
    t_s4 <= t_s3; t_c4 <= t_c3;
    q_s4 <= q_s3; q_c4 <= q_c3;
  end
  function automatic logic signed [16:0] fin(input logic [31:0] s, input logic [1:0] q);
    logic [31:0] r;
    r = (s + 32'd16384) >> 15;
    if (r > 32'd32767) r = 32'd32767;
    return q[1] ? -17'(r) : 17'(r);
  endfunction
  logic [31:0] sw_s, sw_c;
  logic        s5_v;
  logic [AW-1:0] s5_a;
  logic signed [3:0] s5_i, s5_j, s5_k;
  always_ff @(posedge clk) begin
    s5_v <= s4_v; s5_a <= s4_a;
    s5_i <= s4_i; s5_j <= s4_j; s5_k <= s4_k;
    sw_s <= 32'((64'(w_s) * 64'(t_s4)) >> 30);
    sw_c <= 32'((64'(w_c) * 64'(t_c4)) >> 30);
    q_s5 <= q_s4; q_c5 <= q_c4;
  end
  logic signed [32:0] pc, ps;
  logic        s6_v;
  logic [AW-1:0] s6_a;
  logic signed [3:0] s6_i, s6_j, s6_k;
  always_ff @(posedge clk) begin
    s6_v <= s5_v; s6_a <= s5_a;
    s6_i <= s5_i; s6_j <= s5_j; s6_k <= s5_k;
    pc <= 33'(req.scatter_len) * 33'(fin(sw_c, q_c5));
    ps <= 33'(req.scatter_len) * 33'(fin(sw_s, q_s5));
  end

  // rams: read issued at stage 5 so data lands with the products in stage 6
  logic [SumW-1:0] c_rd, s_rd, c_wd, s_wd;
  logic we;
  logic [AW-1:0] wa;
  sfa_ram #(.WIDTH(SumW), .DEPTH(Slots)) u_cos (
    .clk, .we, .waddr(wa), .wdata(c_wd), .raddr(s5_a), .rdata(c_rd));
  sfa_ram #(.WIDTH(SumW), .DEPTH(Slots)) u_sin (
    .clk, .we, .waddr(wa), .wdata(s_wd), .raddr(s5_a), .rdata(s_rd));

  function automatic logic [SumW-1:0] sat(input logic [SumW-1:0] a,
                                          input logic signed [33:0] d);
    logic signed [SumW:0] v;
    v = {a[SumW-1], a} + (SumW+1)'(d);
    if (v[SumW] != v[SumW-1]) return v[SumW] ? {1'b1, {(SumW-1){1'b0}}}
                                             : {1'b0, {(SumW-1){1'b1}}};
    return v[SumW-1:0];
  endfunction

  // each entry is touched once per sweep, so no read-after-write overlap
  always_comb begin
    if (state == ST_CLEAR) begin
      we = 1'b1; wa = clr_addr; c_wd = '0; s_wd = '0;
    end else begin
      we = s6_v && (req.command == CMD_ACCUM);
      wa = s6_a;
      c_wd = sat(c_rd, 34'(pc));
      s_wd = sat(s_rd, -34'(ps));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR; clr_addr <= '0; res_valid <= 1'b0;
      ci <= '0; cj <= '0; ck <= '0; lidx <= '0; drain <= '0;
    end else begin
      state <= state_next;
      // output register loads in ST_OUT, drops once taken
      res_valid <= (state == ST_OUT) || (res_valid && !out_ready);
      unique case (state)
        ST_IDLE: if (in_valid) begin
          req <= in_data; clr_addr <= '0; lidx <= '0;
          ci <= -(CW+1)'(ord); cj <= -(CW+1)'(ord); ck <= -(CW+1)'(ord);
          hit <= '0;
        end
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_SWEEP: begin
          if (in_shell) lidx <= lidx + 1'b1;
          if (ck == (CW+1)'(ord)) begin
            ck <= -(CW+1)'(ord);
            if (cj == (CW+1)'(ord)) begin cj <= -(CW+1)'(ord); ci <= ci + 1'b1; end
            else cj <= cj + 1'b1;
          end else ck <= ck + 1'b1;
          drain <= 4'd6;
        end
        ST_DRAIN: drain <= drain - 1'b1;
        ST_OUT: if (!res_valid || out_ready) begin
          res <= res_next;
        end
        default: ;
      endcase
      if (s6_v && req.command == CMD_READ && 9'(s6_a) == 9'(req.entry_index)
          && state != ST_IDLE) begin
        hit.k_x <= s6_i; hit.k_y <= s6_j; hit.k_z <= s6_k;
        hit.c_sum <= c_rd; hit.s_sum <= s_rd; hit.entry_valid <= 1'b1;
      end
    end
  end
endmodule

// ===== rtl/core/sfa_ram.sv =====
// generic single-port-write ram with registered read
module sfa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/sfa_checker.sv =====
// port-level checker for the structure factor accumulator
`include "structure_factor_accumulator_defines.svh"
module sfa_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input sfa_pkg::sfa_in_t in_data,
  input logic out_valid,
  input logic out_ready,
  input sfa_pkg::sfa_out_t out_data
);
  import sfa_pkg::*;
  `SFA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `SFA_ASSERT_IMP(a_invalid_zero, clk, rst, out_valid && !out_data.entry_valid, out_data.c_sum == 48'sd0)
  `SFA_ASSERT_NXT(a_busy_after_req, clk, rst, in_valid && in_ready && in_data.command != CMD_NONE, !in_ready)
endmodule

bind structure_factor_accumulator sfa_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data);

// ===== tb/structure_factor_accumulator_checker.sv =====
// checker for the structure factor accumulator: predicts read results and compares them
`timescale 1ns / 1ps
module structure_factor_accumulator_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sfa_pkg::sfa_in_t    in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sfa_pkg::sfa_out_t   out_data,
  output int                  fails,
  output int                  pending,
  output int                  reads_checked
);
  import sfa_pkg::*;

  localparam longint SumHi = 64'sd140737488355327;
  localparam longint SumLo = -64'sd140737488355328;

  longint cos_acc [0:255];
  longint sin_acc [0:255];
  logic [2:0] order_reg;
  sfa_out_t read_q [$];

  function automatic int shell_order(logic [2:0] r);
    if (r == 3'd0) return 1;
    if (r > 3'd4) return 4;
    return int'(r);
  endfunction

  // polynomial sine of a 16-bit phase, q1.15
  function automatic longint sine_q15(logic [15:0] ph);
    logic [63:0] t, t2, u, w, s, r;
    t = {48'd0, 2'b00, ph[13:0]} << 16;
    if (ph[14]) t = (64'd1 << 30) - t;
    t2 = (t * t) >> 30;
    u = CoefB - ((CoefC * t2) >> 30);
    w = CoefA - ((u * t2) >> 30);
    s = (w * t) >> 30;
    r = (s + (64'd1 << 14)) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return ph[15] ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sat_sum(longint a, longint d);
    longint v;
    v = a + d;
    if (v > SumHi) return SumHi;
    if (v < SumLo) return SumLo;
    return v;
  endfunction

  // walks the shell: accumulates a particle or looks up one entry
  task automatic sweep_shell(sfa_in_t req);
    int o, n, l;
    logic [15:0] ph;
    longint b;
    sfa_out_t res;
    o = shell_order(order_reg);
    l = 0;
    b = longint'(req.scatter_len);
    res = '0;
    for (int i = -o; i <= o; i++)
      for (int j = -o; j <= o; j++)
        for (int k = -o; k <= o; k++) begin
          n = i * i + j * j + k * k;
          if (n >= 1 && n <= o * o) begin
            if (req.command == CMD_ACCUM) begin
              ph = 16'(i * int'(req.pos_x) + j * int'(req.pos_y) + k * int'(req.pos_z));
              cos_acc[l] = sat_sum(cos_acc[l], b * sine_q15(ph + 16'h4000));
              sin_acc[l] = sat_sum(sin_acc[l], -(b * sine_q15(ph)));
            end else if (l == int'(req.entry_index)) begin
              res.k_x = 4'(i);
              res.k_y = 4'(j);
              res.k_z = 4'(k);
              res.c_sum = 48'(cos_acc[l]);
              res.s_sum = 48'(sin_acc[l]);
              res.entry_valid = 1'b1;
            end
            l++;
          end
        end
    if (req.command == CMD_READ) begin
      res.entry_count = 9'(l);
      read_q.push_back(res);
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk) begin
    sfa_out_t want;
    if (rst) begin
      for (int e = 0; e < 256; e++) begin
        cos_acc[e] = 0;
        sin_acc[e] = 0;
      end
      order_reg = 3'd1;
      fails = 0;
      reads_checked = 0;
      read_q.delete();
    end else begin
      if (cfg_we) order_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        case (in_data.command)
          CMD_CLEAR: for (int e = 0; e < 256; e++) begin
            cos_acc[e] = 0;
            sin_acc[e] = 0;
          end
          CMD_ACCUM, CMD_READ: sweep_shell(in_data);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (read_q.size() == 0) begin
          report("unexpected result", 64'(out_data.entry_count), 64'd0);
        end else begin
          want = read_q.pop_front();
          reads_checked++;
          check_field("k_x", 64'(out_data.k_x), 64'(want.k_x));
          check_field("k_y", 64'(out_data.k_y), 64'(want.k_y));
          check_field("k_z", 64'(out_data.k_z), 64'(want.k_z));
          check_field("c_sum", 64'(out_data.c_sum), 64'(want.c_sum));
          check_field("s_sum", 64'(out_data.s_sum), 64'(want.s_sum));
          check_field("entry_valid", 64'(out_data.entry_valid), 64'(want.entry_valid));
          check_field("entry_count", 64'(out_data.entry_count), 64'(want.entry_count));
        end
      end
    end
    pending = read_q.size();
  end
endmodule

// ===== tb/structure_factor_accumulator_tb.sv =====
// testbench top for the structure factor accumulator: stimulus, stalls and verdict
`timescale 1ns / 1ps
module structure_factor_accumulator_tb;
  import sfa_pkg::*;

  // cycles with no handshake before giving up; covers the clearing pass after reset,
  // one full lattice sweep, the longest sender gap and the settle wait
  localparam int StallLimit = 5000;
  // wait past the longest sweep with its drain and past a full clear before
  // touching the order register
  localparam int SettleCycles = 800;
  localparam int RandomItems = 1950;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  sfa_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sfa_out_t out_data;

  int fails, pending, reads_checked;
  int burst_left = 0;
  int idle_cycles = 0;
  int accum_sent = 0, read_sent = 0, clear_sent = 0, orders_used = 0;
  int stall_run = 0;
  int stall_pct = 30;

  always #4 clk = ~clk;

  structure_factor_accumulator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  structure_factor_accumulator_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fails(fails), .pending(pending), .reads_checked(reads_checked)
  );

  // result side: holds ready at one level for a random run, low with the chance set by stall_pct
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run <= $urandom_range(1, 12);
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // watchdog: nothing moving on either channel for too long ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("structure_factor_accumulator_tb: done, errors");
      $finish;
    end
  end

  // shell sizes for effective orders 1..4
  function automatic int shell_size(logic [2:0] r);
    case (r)
      3'd0, 3'd1: return 6;
      3'd2: return 32;
      3'd3: return 122;
      default: return 256;
    endcase
  endfunction

  function automatic sfa_in_t mk(logic [1:0] cmd, logic [15:0] x, logic [15:0] y,
                                 logic [15:0] z, logic [15:0] b, logic [7:0] idx);
    sfa_in_t r;
    r.command = cmd;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    r.scatter_len = b;
    r.entry_index = idx;
    return r;
  endfunction

  // mostly random positions, with the wrap points thrown in
  function automatic logic [15:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one request; leaves valid high if the burst goes on, else idles a gap
  task automatic push(sfa_in_t req);
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    case (req.command)
      CMD_ACCUM: accum_sent++;
      CMD_READ: read_sent++;
      CMD_CLEAR: clear_sent++;
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(0, 15);
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  // drop valid, wait for every result and for any sweep still running
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_order(logic [2:0] r);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    orders_used++;
  endtask

  initial begin
    logic [2:0] cur_order;
    logic [2:0] order_plan [8];
    logic [7:0] idx;
    int pick;
    order_plan = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd1};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset order of one, empty sums, weight extremes, wrap positions
    cur_order = 3'd1;
    push(mk(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0));
    push(mk(CMD_ACCUM, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 8'd0));
    push(mk(CMD_ACCUM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 8'hFF));
    push(mk(CMD_ACCUM, 16'h4000, 16'h8000, 16'hC000, 16'h0001, 8'd0));
    push(mk(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0));
    push(mk(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 8'd5));
    // first index past the shell, then the top index
    push(mk(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 8'd6));
    push(mk(CMD_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255));
    // unknown command changes nothing
    push(mk(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd2));
    push(mk(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 8'd2));
    push(mk(CMD_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0));
    push(mk(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 8'd3));
    push(mk(CMD_ACCUM, 16'h2000, 16'h1000, 16'h0800, 16'h7FFF, 8'd0));
    push(mk(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 8'd1));

    // hold off until the result side has drained everything
    settle();

    // random phases, each under a new order; sums carry over between orders
    for (int ph = 0; ph < 8; ph++) begin
      cur_order = order_plan[ph];
      stall_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 30 : 70;
      set_order(cur_order);
      for (int n = 0; n < RandomItems / 8; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) idx = 8'($urandom);
        else if ($urandom_range(0, 4) == 0) idx = 8'($urandom);
        else idx = 8'($urandom_range(0, shell_size(cur_order) - 1));
        if (pick < 3)
          push(mk(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), idx));
        else if (pick < 6)
          push(mk(CMD_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), idx));
        else if (pick < 55)
          push(mk(CMD_ACCUM, pick_pos(), pick_pos(), pick_pos(), pick_weight(), idx));
        else
          push(mk(CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), idx));
      end
    end

    settle();
    $display("covered %0d accumulates, %0d reads (%0d results checked), %0d clears",
             accum_sent, read_sent, reads_checked, clear_sent);
    $display("across %0d order settings including 0 and 7, with varied stall levels",
             orders_used);
    if (fails == 0) begin
      $display("structure_factor_accumulator_tb: done, clean");
    end else begin
      $display("structure_factor_accumulator_tb: done, errors");
    end
    $finish;
  end
endmodule
